// ===== design/top_percent_select_macros.svh =====
// Assertion macros shared by the percentile select block.
`ifndef TOP_PERCENT_SELECT_MACROS_SVH
`define TOP_PERCENT_SELECT_MACROS_SVH

// Same-cycle implication checked on every rising edge outside reset.
`define TPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("percent select: same-cycle check failed");

// Next-cycle implication checked on every rising edge outside reset.
`define TPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("percent select: next-cycle check failed");

`endif

// ===== design/tps_pkg.sv =====
// Types, constants and helpers shared by the percentile select block.
`timescale 1ns / 1ps
package tps_pkg;

  localparam int CNT_W       = 7;
  localparam int IDX_W       = 6;
  localparam int VAL_W       = 32;
  localparam int PCT_W       = 7;
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd100;
  localparam logic [PCT_W-1:0] FULL_PCT  = 7'd100;

  // k = (n * p + 99) / 100, the division done as a multiply by 2^20 / 100.
  localparam int PROD_W      = 13;
  localparam int RECIP_W     = 14;
  localparam int RECIP_SHIFT = 20;
  localparam int Q_W         = PROD_W + RECIP_W;
  localparam logic [PROD_W-1:0]  ROUND_UP = 13'd99;
  localparam logic [RECIP_W-1:0] RECIP    = 14'd10486;

  typedef struct packed {
    logic signed [VAL_W-1:0] intensity;
    logic                    last;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] item_index;
    logic [CNT_W-1:0] selected_count;
    logic             empty_res;
    logic             last_res;
  } result_t;

  typedef struct packed {
    logic load;
    logic mult;
    logic div;
    logic cand_rd;
    logic cand_latch;
    logic scan_rd;
    logic take_thr;
    logic next_cand;
    logic emit_rd;
    logic emit_sel;
    logic next_emit;
    logic emit_empty;
  } tps_cmd_t;

  typedef struct packed {
    logic zero_sel;
    logic scan_last;
    logic found;
    logic cand_last;
    logic hit;
    logic out_free;
    logic emit_last;
    logic sel_done;
  } tps_status_t;

  // Flipping the sign bit makes unsigned order match signed order.
  function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] v);
    order_key = {~v[VAL_W-1], v[VAL_W-2:0]};
  endfunction

endpackage

// ===== design/tps_datapath.sv =====
// Value store, threshold search counters and result register.
`timescale 1ns / 1ps
module tps_datapath #(
  parameter int MAX_ITEMS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tps_pkg::item_t        item,
  input  logic                  percent_valid,
  input  logic [6:0]            percent_data,
  input  tps_pkg::tps_cmd_t     cmd,
  output tps_pkg::tps_status_t  st,
  output logic                  result_valid,
  input  logic                  result_stall,
  output tps_pkg::result_t      result
);
  import tps_pkg::*;

  localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

  logic [VAL_W-1:0]  mem [MAX_ITEMS];
  logic [VAL_W-1:0]  rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;

  logic [PCT_W-1:0]  percent;
  logic [PCT_W-1:0]  p_eff;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              store_ok;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  n_less;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    q_full;
  logic [CNT_W-1:0]  k_div;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  cand;
  logic [CNT_W-1:0]  j;
  logic [CNT_W-1:0]  greater;
  logic [CNT_W-1:0]  atleast;
  logic [CNT_W-1:0]  tot;
  logic [CNT_W-1:0]  sel;
  logic [CNT_W-1:0]  sel_inc;
  logic [VAL_W-1:0]  cand_key;
  logic [VAL_W-1:0]  thr;
  logic [VAL_W-1:0]  rd_key;
  logic              rv;

  assign store_ok   = count < CNT_W'(MAX_ITEMS);
  assign count_next = store_ok ? count + CNT_W'(1) : count;
  assign p_eff      = (percent > FULL_PCT) ? FULL_PCT : percent;
  assign n_less     = n - CNT_W'(1);
  assign q_full     = Q_W'(prod) * Q_W'(RECIP);
  assign k_div      = q_full[RECIP_SHIFT +: CNT_W];
  assign rd_key     = order_key(rd_data);
  assign sel_inc    = sel + CNT_W'(1);

  assign rd_en   = cmd.cand_rd | cmd.scan_rd | cmd.emit_rd;
  assign rd_addr = cmd.cand_rd ? cand[ADDR_W-1:0] : j[ADDR_W-1:0];

  always_comb begin
    st.zero_sel  = (p_eff == '0) || (n == '0);
    st.scan_last = (j == n_less);
    st.found     = (greater < k) && (k <= atleast);
    st.cand_last = (cand == n_less);
    st.hit       = rd_key >= thr;
    st.out_free  = !result_valid || !result_stall;
    st.emit_last = (j == n_less);
    st.sel_done  = (sel_inc == tot);
  end

  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) mem[count[ADDR_W-1:0]] <= item.intensity;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      percent      <= PCT_RESET;
      rv           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (percent_valid) percent <= percent_data;
      if (cmd.load) begin
        count <= item.last ? '0 : count_next;
      end
      rv <= cmd.scan_rd;
      if (cmd.emit_sel || cmd.emit_empty) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && item.last) n <= count_next;
    if (cmd.mult) prod <= PROD_W'(n) * PROD_W'(p_eff) + ROUND_UP;
    if (cmd.div) begin
      k    <= (k_div > n) ? n : k_div;
      cand <= '0;
    end
    if (cmd.next_cand) cand <= cand + CNT_W'(1);
    if (cmd.cand_latch) begin
      cand_key <= rd_key;
      j        <= '0;
      greater  <= '0;
      atleast  <= '0;
    end
    if (cmd.scan_rd || cmd.next_emit) j <= j + CNT_W'(1);
    if (rv) begin
      if (rd_key > cand_key) greater <= greater + CNT_W'(1);
      if (rd_key >= cand_key) atleast <= atleast + CNT_W'(1);
    end
    // Everything at or above the threshold is selected, so the total is known here.
    if (cmd.take_thr) begin
      thr <= cand_key;
      tot <= atleast;
      j   <= '0;
      sel <= '0;
    end
    if (cmd.emit_sel) begin
      result.item_index     <= j[IDX_W-1:0];
      result.selected_count <= sel_inc;
      result.empty_res      <= 1'b0;
      result.last_res       <= st.sel_done || st.emit_last;
      sel                   <= sel_inc;
    end
    if (cmd.emit_empty) begin
      result.item_index     <= '0;
      result.selected_count <= '0;
      result.empty_res      <= 1'b1;
      result.last_res       <= 1'b1;
    end
  end

endmodule

// ===== design/tps_controller.sv =====
// Sequencer for loading, threshold search and in-order emission.
`timescale 1ns / 1ps
module tps_controller (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  input  logic                  item_last,
  output logic                  item_stall,
  input  tps_pkg::tps_status_t  st,
  output tps_pkg::tps_cmd_t     cmd
);
  import tps_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_MULT,
    S_DIV,
    S_CAND_RD,
    S_CAND_LATCH,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_EMIT_RD,
    S_EMIT_CHK,
    S_EMPTY
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign item_stall = (state != S_LOAD);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        cmd.load = accept;
        if (accept && item_last) state_next = S_MULT;
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = st.zero_sel ? S_EMPTY : S_DIV;
      end
      S_DIV: begin
        cmd.div    = 1'b1;
        state_next = S_CAND_RD;
      end
      S_CAND_RD: begin
        cmd.cand_rd = 1'b1;
        state_next  = S_CAND_LATCH;
      end
      S_CAND_LATCH: begin
        cmd.cand_latch = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (st.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.found || st.cand_last) begin
          cmd.take_thr = 1'b1;
          state_next   = S_EMIT_RD;
        end else begin
          cmd.next_cand = 1'b1;
          state_next    = S_CAND_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next  = S_EMIT_CHK;
      end
      S_EMIT_CHK: begin
        if (st.hit) begin
          if (st.out_free) begin
            cmd.emit_sel = 1'b1;
            if (st.emit_last || st.sel_done) begin
              state_next = S_LOAD;
            end else begin
              cmd.next_emit = 1'b1;
              state_next    = S_EMIT_RD;
            end
          end
        end else if (st.emit_last) begin
          state_next = S_LOAD;
        end else begin
          cmd.next_emit = 1'b1;
          state_next    = S_EMIT_RD;
        end
      end
      S_EMPTY: begin
        if (st.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/top_percent_select.sv =====
// Top level of the percentile threshold select block.
//
// Items arrive on the item channel (item_valid / item_stall) and are stored in
// load order, one per cycle while loading, until an item with last set closes
// the set. Items past MAX_ITEMS are dropped, but their last mark still closes
// the set. The share to keep is written on the percent channel (percent_valid /
// percent_ready, always ready); the user must write it only while the block is
// idle, not enforced by the block. Reset sets it to 100. After the closing
// item the block stalls its input, works out k = ceil(n * percent / 100) in a
// multiply and a divide state, then searches for the k-th largest value; the
// single read port of the value store is swept once per candidate. Emission
// then reads the store again, each item in a read and a check state, and
// issues one request on the result channel for every value at or above the
// threshold, in load order, last_res marking the final one. With percent zero
// one empty request is given instead. A stalled result holds in the output
// register and the sweep waits; the next set may start loading while the final
// request still waits. Reset returns to loading, empty store.
`timescale 1ns / 1ps
`include "top_percent_select_macros.svh"
module top_percent_select #(
  parameter int MAX_ITEMS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  tps_pkg::item_t   item,
  input  logic             percent_valid,
  output logic             percent_ready,
  input  logic [6:0]       percent_data,
  output logic             result_valid,
  input  logic             result_stall,
  output tps_pkg::result_t result
);
  import tps_pkg::*;

  tps_cmd_t    cmd;
  tps_status_t st;

  assign percent_ready = 1'b1;

  tps_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_last  (item.last),
    .item_stall (item_stall),
    .st         (st),
    .cmd        (cmd)
  );

  tps_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .percent_valid (percent_valid && percent_ready),
    .percent_data  (percent_data),
    .cmd           (cmd),
    .st            (st),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  `TPS_ASSERT_IMPL(a_empty_shape, clk, rst, result_valid && result.empty_res, result.last_res && (result.selected_count == '0))
  `TPS_ASSERT_IMPL(a_sel_count, clk, rst, result_valid && !result.empty_res, result.selected_count != '0)
  `TPS_ASSERT_NEXT(a_close_stalls, clk, rst, item_valid && !item_stall && item.last, item_stall)

endmodule

// ===== dv/percent_select_checker.sv =====
// Checker for the percentile select block: predicts each set's results and compares them.
`timescale 1ns / 1ps
module percent_select_checker #(
  parameter int MAX_ITEMS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  tps_pkg::item_t   item,
  input  logic             percent_valid,
  input  logic             percent_ready,
  input  logic [6:0]       percent_data,
  input  logic             result_valid,
  input  logic             result_stall,
  input  tps_pkg::result_t result,
  output int               errors,
  output int               pending
);
  import tps_pkg::*;

  localparam int unsigned ROUND_UP_ADD = 99;
  localparam int unsigned PCT_SCALE    = 100;
  localparam int          REPORT_MAX   = 10;

  logic signed [VAL_W-1:0] loaded_vals [MAX_ITEMS];
  int unsigned             loaded_cnt;
  logic [PCT_W-1:0]        keep_pct;
  result_t                 selections_q [$];
  int                      mismatches;

  // The k-th largest loaded value, with duplicates counted one by one.
  function automatic logic signed [VAL_W-1:0] kth_largest(input int unsigned n,
                                                          input int unsigned k);
    int unsigned above;
    int unsigned not_below;
    for (int i = 0; i < n; i++) begin
      above = 0;
      not_below = 0;
      for (int j = 0; j < n; j++) begin
        if (loaded_vals[j] > loaded_vals[i]) above++;
        if (loaded_vals[j] >= loaded_vals[i]) not_below++;
      end
      if (above < k && k <= not_below) return loaded_vals[i];
    end
    return loaded_vals[0];
  endfunction

  // Closes the current set and queues the selections it yields.
  function automatic void close_set();
    int unsigned n;
    int unsigned p;
    int unsigned k;
    int unsigned total;
    int unsigned sel;
    logic signed [VAL_W-1:0] thr;
    result_t r;
    n = loaded_cnt;
    loaded_cnt = 0;
    p = (keep_pct > FULL_PCT) ? FULL_PCT : keep_pct;
    r = '0;
    if (p == 0 || n == 0) begin
      r.empty_res = 1'b1;
      r.last_res = 1'b1;
      selections_q.push_back(r);
      return;
    end
    k = (n * p + ROUND_UP_ADD) / PCT_SCALE;
    if (k < 1) k = 1;
    if (k > n) k = n;
    thr = kth_largest(n, k);
    total = 0;
    for (int i = 0; i < n; i++) begin
      if (loaded_vals[i] >= thr) total++;
    end
    sel = 0;
    for (int i = 0; i < n; i++) begin
      if (loaded_vals[i] >= thr) begin
        sel++;
        r.item_index = i[IDX_W-1:0];
        r.selected_count = sel[CNT_W-1:0];
        r.empty_res = 1'b0;
        r.last_res = (sel == total);
        selections_q.push_back(r);
      end
    end
  endfunction

  function automatic void report(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX) begin
      $display("%s: expected index %0d count %0d empty %0b last %0b, got index %0d count %0d empty %0b last %0b",
               what, want.item_index, want.selected_count, want.empty_res, want.last_res,
               got.item_index, got.selected_count, got.empty_res, got.last_res);
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      loaded_cnt = 0;
      keep_pct = PCT_RESET;
      selections_q.delete();
      mismatches = 0;
    end else begin
      if (percent_valid && percent_ready) keep_pct = percent_data;
      if (item_valid && !item_stall) begin
        if (loaded_cnt < MAX_ITEMS) begin
          loaded_vals[loaded_cnt] = item.intensity;
          loaded_cnt++;
        end
        if (item.last) close_set();
      end
      if (result_valid && !result_stall) begin
        if (selections_q.size() == 0) begin
          report("unexpected request", '0, result);
        end else begin
          want = selections_q.pop_front();
          // The index carries no meaning on an empty result.
          if ((!want.empty_res && result.item_index !== want.item_index) ||
              result.selected_count !== want.selected_count ||
              result.empty_res !== want.empty_res ||
              result.last_res !== want.last_res) begin
            report("request mismatch", want, result);
          end
        end
      end
    end
    pending <= selections_q.size();
    errors <= mismatches;
  end

endmodule

// ===== dv/top_percent_select_test.sv =====
// Testbench top for the percentile select block: stimulus, pacing and verdict.
`timescale 1ns / 1ps
module top_percent_select_test;
  import tps_pkg::*;

  localparam int MAX_ITEMS     = 64;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 64;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_ITEMS   = 20;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  item_t            item = '0;
  logic             percent_valid = 1'b0;
  logic [PCT_W-1:0] percent_data = '0;
  logic             result_stall = 1'b0;
  logic             item_stall;
  logic             percent_ready;
  logic             result_valid;
  result_t          result;
  int               errors;
  int               pending;
  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               hold_left = 0;
  int               cycles = 0;

  always #1 clk = ~clk;

  top_percent_select #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .percent_valid(percent_valid),
    .percent_ready(percent_ready),
    .percent_data(percent_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  percent_select_checker #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .percent_valid(percent_valid),
    .percent_ready(percent_ready),
    .percent_data(percent_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .errors(errors),
    .pending(pending)
  );

  // Result side: a long hold-off when asked for, random stalls otherwise.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mixes wide random values with extremes and a narrow range that forces ties.
  function automatic logic signed [VAL_W-1:0] rand_intensity();
    case ($urandom_range(3))
      0: return $signed($urandom_range(6)) - 3;
      1: begin
        case ($urandom_range(3))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PCT_W-1:0] rand_percent();
    case ($urandom_range(7))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd50;
      3: return 7'd99;
      4: return 7'd100;
      5: return 7'd101;
      6: return 7'd127;
      default: return $urandom_range(127);
    endcase
  endfunction

  task automatic send_item(input logic signed [VAL_W-1:0] value, input logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= {value, is_last};
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_set(input int size);
    for (int i = 0; i < size; i++) send_item(rand_intensity(), i == size - 1);
  endtask

  // Waits until every queued selection has come back and the block is idle.
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_percent(input logic [PCT_W-1:0] p);
    drain();
    percent_valid <= 1'b1;
    percent_data <= p;
    do @(posedge clk); while (!percent_ready);
    percent_valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int size;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed sets: extremes, percent zero, one, above 100, ties, a single item.
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item('0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b1);
    set_percent(7'd0);
    send_item(5, 1'b0);
    send_item(7, 1'b1);
    set_percent(7'd1);
    send_item(3, 1'b0);
    send_item(3, 1'b0);
    send_item(-2, 1'b1);
    set_percent(7'd127);
    send_item(VAL_MIN, 1'b0);
    send_item(VAL_MIN, 1'b1);
    set_percent(7'd50);
    send_item(VAL_MAX, 1'b0);
    send_item(-1, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(VAL_MAX, 1'b0);
    send_item('0, 1'b1);
    set_percent(7'd100);
    send_item('0, 1'b1);
    set_percent(7'd99);
    send_item(-7, 1'b0);
    send_item(12, 1'b0);
    send_item(-7, 1'b0);
    send_item(VAL_MAX, 1'b1);

    // Keep the result side blocked while sets keep coming so the block backs up.
    drain();
    hold_left <= HOLD_CYCLES;
    for (int s = 0; s < 6; s++) send_set($urandom_range(1, 5));
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 54; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 54; end
        default: begin send_idle_pct = 21; stall_pct <= 21; end
      endcase
      // A full store once, and once a set that overflows so its tail is dropped.
      if (phase == 1) send_set(MAX_ITEMS);
      if (phase == 3) send_set($urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(2) == 0) set_percent(rand_percent());
        size = $urandom_range(1, 8);
        send_set(size);
        sent += size;
      end
      set_percent(rand_percent());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
